[rtl/core/vid_pkg.sv]
// Package for the vertex index dedup block: sizes, beat types, key RAM request.
// No dependencies; used by every module under rtl/core.
package vid_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int INDEX_BITS    = 16;

	localparam int IN_FIELD_W  = 16;
	localparam int OUT_IDX_W   = 12;
	localparam int ADDR_W      = $clog2(TABLE_ENTRIES);
	localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
	// only the low INDEX_BITS of each 16-bit field take part in the key
	localparam int KEY_FIELD_W = (INDEX_BITS < IN_FIELD_W) ? INDEX_BITS : IN_FIELD_W;
	localparam int KEY_W       = 3 * KEY_FIELD_W;

	typedef struct packed {
		logic                  group_start;
		logic [IN_FIELD_W-1:0] position_index;
		logic [IN_FIELD_W-1:0] normal_index;
		logic [IN_FIELD_W-1:0] texcoord_index;
	} in_beat_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] out_index;
		logic                 was_new;
		logic                 overflow;
	} out_beat_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [KEY_W-1:0] make_key(input in_beat_t b);
		return {b.position_index[KEY_FIELD_W-1:0],
			b.normal_index[KEY_FIELD_W-1:0],
			b.texcoord_index[KEY_FIELD_W-1:0]};
	endfunction

	// low OUT_IDX_W bits of a compact index, zero-extended if narrower
	function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [CNT_W-1:0] idx);
		logic [CNT_W+OUT_IDX_W-1:0] w;
		w = (CNT_W + OUT_IDX_W)'(idx);
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

[rtl/core/vid_key_ram.sv]
// Key store: one-port-write, one-port-read synchronous RAM; read data is registered.
// Depends on vid_pkg (sizes, ram_req_t).
module vid_key_ram (
	input  logic                    clk,
	input  vid_pkg::ram_req_t       req,
	output logic [vid_pkg::KEY_W-1:0] rdata
);

	logic [vid_pkg::KEY_W-1:0] mem [vid_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

[rtl/core/vid_scan_ctrl.sv]
// Lookup/insert sequencer: scans the key RAM below the entry count, then returns the hit
// index, appends the key, or flags overflow if the table is full. Depends on vid_pkg.
module vid_scan_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  vid_pkg::in_beat_t         corner,
	output logic                      busy,
	output logic                      done,
	output vid_pkg::out_beat_t        result,
	output vid_pkg::ram_req_t         ram_req,
	input  logic [vid_pkg::KEY_W-1:0] ram_rdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                      state_q;
	logic [vid_pkg::CNT_W-1:0] count_q;
	logic [vid_pkg::CNT_W-1:0] issue_ptr_q;
	logic                      rvalid_s1;
	logic [vid_pkg::CNT_W-1:0] ridx_s1;
	logic [vid_pkg::KEY_W-1:0] key_q;
	logic                      done_q;
	vid_pkg::out_beat_t        result_q;

	logic hit, miss, full, issue, accept;

	assign accept = start && (state_q == ST_IDLE);
	assign hit    = rvalid_s1 && (ram_rdata == key_q);
	// every entry below the count has been read and compared
	assign miss   = (state_q == ST_SCAN) && !rvalid_s1 && (issue_ptr_q == count_q);
	assign full   = (count_q == vid_pkg::CNT_W'(vid_pkg::TABLE_ENTRIES));
	assign issue  = (state_q == ST_SCAN) && !hit && (issue_ptr_q != count_q);

	always_comb begin
		ram_req.re    = issue;
		ram_req.raddr = issue_ptr_q[vid_pkg::ADDR_W-1:0];
		ram_req.we    = miss && !full;
		ram_req.waddr = count_q[vid_pkg::ADDR_W-1:0];
		ram_req.wdata = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_ptr_q <= '0;
			rvalid_s1   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rvalid_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issue_ptr_q <= '0;
						if (corner.group_start) begin
							count_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_ptr_q <= issue_ptr_q + 1'b1;
					end
					if (hit || miss) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
					if (miss && !full) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= vid_pkg::make_key(corner);
		end
		if (issue) begin
			ridx_s1 <= issue_ptr_q;
		end
		if (hit) begin
			result_q.out_index <= vid_pkg::to_out_index(ridx_s1);
			result_q.was_new   <= 1'b0;
			result_q.overflow  <= 1'b0;
		end else if (miss && full) begin
			result_q.out_index <= '0;
			result_q.was_new   <= 1'b0;
			result_q.overflow  <= 1'b1;
		end else if (miss) begin
			result_q.out_index <= vid_pkg::to_out_index(count_q);
			result_q.was_new   <= 1'b1;
			result_q.overflow  <= 1'b0;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vid_pkg::CNT_W'(vid_pkg::TABLE_ENTRIES))
		else $error("entry count beyond table size");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_ptr_q <= count_q)
		else $error("scan pointer ran past entry count");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (count_q < vid_pkg::CNT_W'(vid_pkg::TABLE_ENTRIES)))
		else $error("key write into a full table");
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_SCAN) && (state_q == ST_IDLE))
		else $error("result beat without a finished scan");
	a_rvalid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> (state_q == ST_SCAN))
		else $error("read data arrives outside a scan");

endmodule

[rtl/core/vertex_index_dedup_top.sv]
// Vertex index dedup: maps (position, normal, texcoord) triples to compact indices.
// Throughput: one corner at a time; start is taken again in the cycle the result is shown.
// The rate is set by the linear scan of the key RAM, one entry read per cycle.
// Reset: entry count cleared, key RAM contents undefined (never read before written).
// The result beat is shown for one cycle on done; the receiver cannot stall.
module vertex_index_dedup_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  vid_pkg::in_beat_t  corner,
	output logic               busy,
	output logic               done,
	output vid_pkg::out_beat_t result
);

	// request from the sequencer to the key store, read data back
	vid_pkg::ram_req_t         ram_req;
	logic [vid_pkg::KEY_W-1:0] ram_rdata;

	// sequencer: compare each stored key in turn, append on miss while the table has room
	vid_scan_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.corner    (corner),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// key store; an entry written on a miss is read again only in a later scan
	vid_key_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule
